>>> src/pre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Printable run extractor package
// Shared request types, control and status groups, and character constants.
// ----------------------------------------------------------------------------
package pre_pkg;

  localparam int CFG_W = 7;

  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_PRINT_LO = 8'd32;
  localparam logic [7:0] CHAR_PRINT_HI = 8'd126;
  localparam logic [6:0] CHAR_NEWLINE = 7'd10;
  localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 7'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_byte;
    logic       string_end;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic flush_emit;
    logic tail_emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic need_flush;
    logic flush_last;
  } dp_status_t;

endpackage

>>> src/pre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Printable run extractor controller
// Sequences request intake, replay of the buffered run prefix and the tail.
// ----------------------------------------------------------------------------
module pre_ctrl import pre_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_TAIL  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_stall = !((state == ST_IDLE) && status.out_free);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = in_valid && status.out_free;
        if (cmd.accept && status.need_flush) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.flush_emit = 1'b1;
          if (status.flush_last) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        if (status.out_free) begin
          cmd.tail_emit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> src/pre_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Printable run extractor datapath
// Run counter, prefix buffer, configuration register and output register.
// ----------------------------------------------------------------------------
module pre_dpath import pre_pkg::*; #(
  parameter int MAX_MIN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  in_item_t         in_data,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             out_stall,
  output logic             out_valid,
  output out_item_t        out_data,
  input  ctl_cmd_t         cmd,
  output dp_status_t       status
);

  localparam int DEPTH = (MAX_MIN > 1) ? MAX_MIN - 1 : 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(MAX_MIN + 1);

  logic [CFG_W-1:0] min_length;
  logic [CW-1:0]    run_count;
  logic             reported;
  logic [CW-1:0]    flush_len;
  logic [AW-1:0]    flush_idx;
  logic [6:0]       tail_byte;
  logic             tail_end;

  logic [6:0] pending_bytes [DEPTH];
  logic [6:0] rd_data;

  logic [CFG_W-1:0] eff_min;
  logic [CFG_W-1:0] run7;
  logic             is_text;
  logic             reach;
  logic             emit_now;
  logic             wr_en;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             load;
  out_item_t        load_item;

  always_comb begin
    if (min_length == '0) begin
      eff_min = CFG_W'(1);
    end else if (min_length > CFG_W'(MAX_MIN)) begin
      eff_min = CFG_W'(MAX_MIN);
    end else begin
      eff_min = min_length;
    end
  end

  assign run7 = CFG_W'(run_count);
  assign is_text = !in_data.end_of_file && ((in_data.in_byte == CHAR_TAB) ||
                   ((in_data.in_byte >= CHAR_PRINT_LO) && (in_data.in_byte <= CHAR_PRINT_HI)));
  assign reach = ({1'b0, run7} + 8'd1) >= {1'b0, eff_min};

  always_comb begin
    status.out_free = !out_valid || !out_stall;
    if (is_text) begin
      status.need_flush = !reported && reach && (run_count != '0);
    end else begin
      status.need_flush = !reported && (run7 >= eff_min);
    end
    status.flush_last = (CW'(flush_idx) + CW'(1)) == flush_len;
  end

  always_comb begin
    emit_now = 1'b0;
    load_item = '0;
    if (is_text) begin
      emit_now = reported || (reach && (run_count == '0));
      load_item = '{out_byte: in_data.in_byte[6:0], string_end: 1'b0, last: 1'b1};
    end else begin
      emit_now = reported;
      load_item = '{out_byte: CHAR_NEWLINE, string_end: 1'b1, last: 1'b1};
    end
    if (cmd.flush_emit) begin
      load_item = '{out_byte: rd_data, string_end: 1'b0, last: 1'b0};
    end else if (cmd.tail_emit) begin
      load_item = '{out_byte: tail_byte, string_end: tail_end, last: 1'b1};
    end
  end

  assign load = (cmd.accept && emit_now && !status.need_flush) || cmd.flush_emit ||
                cmd.tail_emit;
  assign wr_en = cmd.accept && is_text && !reported && !reach;
  assign rd_en = (cmd.accept && status.need_flush) ||
                 (cmd.flush_emit && !status.flush_last);
  assign rd_addr = cmd.flush_emit ? flush_idx + AW'(1) : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pending_bytes[run_count[AW-1:0]] <= in_data.in_byte[6:0];
    end
    if (rd_en) begin
      rd_data <= pending_bytes[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= MIN_LENGTH_RESET;
      run_count <= '0;
      reported <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        min_length <= cfg_data;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.accept) begin
        if (is_text) begin
          if (reach) begin
            reported <= 1'b1;
          end
          if (run_count < CW'(MAX_MIN)) begin
            run_count <= run_count + CW'(1);
          end
        end else begin
          run_count <= '0;
          reported <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_item;
    end
    if (cmd.accept && status.need_flush) begin
      flush_len <= run_count;
      flush_idx <= '0;
      tail_byte <= is_text ? in_data.in_byte[6:0] : CHAR_NEWLINE;
      tail_end <= !is_text;
    end else if (cmd.flush_emit) begin
      flush_idx <= flush_idx + AW'(1);
    end
  end

endmodule

>>> src/printable_run_extractor_unit.sv
`timescale 1ns / 1ps
// A byte passed straight through is in the output register the cycle after it is taken.
// Throughput: one byte per cycle for text or prefix storage while the output is free.
// A request that replays a buffered prefix of n bytes stalls the input through FLUSH,
// which emits the n bytes, and TAIL, which emits its own byte or a newline, as set by
// the one read port of the prefix buffer and the single output register.
// Reset is synchronous: it clears the run, the output valid flag and sets min_length to 4.
// ----------------------------------------------------------------------------
// Printable run extractor
// Finds text-byte runs and reports those at least min_length (max MAX_MIN) long.
// ----------------------------------------------------------------------------
module printable_run_extractor_unit import pre_pkg::*; #(
  parameter int MAX_MIN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  pre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  pre_dpath #(
    .MAX_MIN (MAX_MIN)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
